// ===== sv/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Types, codes and the fixed transition table of the TCP connection tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  // Field widths fixed by the item format
  localparam int unsigned CONN_INDEX_W = 12;
  localparam int unsigned TIMEOUT_W    = 32;
  localparam int unsigned COUNT_W      = 13;

  // Command codes
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_OPEN   = 1'b1;

  // Stored tracking state
  typedef enum logic [3:0] {
    ST_NONE = 4'd0,
    ST_SS   = 4'd1,
    ST_SR   = 4'd2,
    ST_ES   = 4'd3,
    ST_FW   = 4'd4,
    ST_CW   = 4'd5,
    ST_LA   = 4'd6,
    ST_TW   = 4'd7,
    ST_CL   = 4'd8,
    ST_SS2  = 4'd9
  } conn_state_e;

  // Table result: a state, or ignore / invalid
  typedef enum logic [3:0] {
    NX_NO = 4'd0,
    NX_SS = 4'd1,
    NX_SR = 4'd2,
    NX_ES = 4'd3,
    NX_FW = 4'd4,
    NX_CW = 4'd5,
    NX_LA = 4'd6,
    NX_TW = 4'd7,
    NX_CL = 4'd8,
    NX_S2 = 4'd9,
    NX_IG = 4'd10,
    NX_IV = 4'd11
  } tct_next_e;

  // Flag class, in table row order
  typedef enum logic [2:0] {
    CLS_SYN    = 3'd0,
    CLS_SYNACK = 3'd1,
    CLS_FIN    = 3'd2,
    CLS_ACK    = 3'd3,
    CLS_RST    = 3'd4,
    CLS_NONE   = 3'd5
  } tct_class_e;

  typedef enum logic [1:0] {
    VD_APPLIED = 2'd0,
    VD_IGNORED = 2'd1,
    VD_INVALID = 2'd2
  } tct_verdict_e;

  typedef enum logic [1:0] {
    CHG_NONE = 2'd0,
    CHG_UP   = 2'd1,
    CHG_DOWN = 2'd2
  } tct_change_e;

  // One memory word per connection
  typedef struct packed {
    logic                 active;
    logic [TIMEOUT_W-1:0] timeout;
    conn_state_e          state;
  } tct_entry_t;

  // Next state by direction, flag class and old state
  localparam tct_next_e NEXT_TAB [2][6][10] = '{
    '{
      '{NX_SS, NX_SS, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_SS, NX_SS, NX_S2},
      '{NX_IV, NX_IV, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_SR},
      '{NX_IV, NX_IV, NX_FW, NX_FW, NX_LA, NX_LA, NX_LA, NX_TW, NX_CL, NX_IV},
      '{NX_ES, NX_IV, NX_ES, NX_ES, NX_CW, NX_CW, NX_TW, NX_TW, NX_CL, NX_IV},
      '{NX_IV, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL},
      '{NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV}
    },
    '{
      '{NX_IV, NX_S2, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_S2},
      '{NX_IV, NX_SR, NX_SR, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_SR},
      '{NX_IV, NX_IV, NX_FW, NX_FW, NX_LA, NX_LA, NX_LA, NX_TW, NX_CL, NX_IV},
      '{NX_IV, NX_IG, NX_SR, NX_ES, NX_CW, NX_CW, NX_TW, NX_TW, NX_CL, NX_IG},
      '{NX_IV, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL},
      '{NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV}
    }
  };

  // Look up the transition; an out-of-range old state is invalid
  function automatic tct_next_e next_lookup(logic dir, tct_class_e cls, conn_state_e old);
    tct_next_e nx;
    if (old > ST_SS2 || cls > CLS_NONE) begin
      nx = NX_IV;
    end else begin
      nx = NEXT_TAB[dir][cls][old];
    end
    return nx;
  endfunction

  // Classify flags: RST, SYN / SYN-ACK, FIN, ACK, none
  function automatic tct_class_e flag_class(logic syn, logic ack, logic fin, logic rst);
    tct_class_e cls;
    if (rst) begin
      cls = CLS_RST;
    end else if (syn) begin
      cls = ack ? CLS_SYNACK : CLS_SYN;
    end else if (fin) begin
      cls = CLS_FIN;
    end else if (ack) begin
      cls = CLS_ACK;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

endpackage

// ===== sv/tcp_conntrack_state_update.sv =====
// ----------------------------------------------------------------------------
// tcp_conntrack_state_update
// Per-connection TCP tracking store: read-modify-write of one entry per item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_ready_o    command, conn_index, reply_dir, flags
//  out      output     out_valid_o/out_ready_i  conn_state, verdict, timeout, activity
//  cfg      input      cfg_valid_i/cfg_ready_o  established_timeout
//
//  One item per cycle sustained while the output is not stalled; after the input
//  transfer come index reduction and memory read, then update and write-back
//  into the output register. The single read and write port of the entry memory
//  sets that rate; the newest write, when it is to the same entry, is forwarded.
//  When the output register is full and not taken, all stages hold.
//  Reset clears the pipeline valids, the last-write valid, the active count and
//  the established timeout; entries are undefined until opened.

module tcp_conntrack_state_update #(
  parameter int unsigned CONN_ENTRIES     = 4096,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [tct_pkg::CONN_INDEX_W-1:0] conn_index_i,
  input  logic                            reply_dir_i,
  input  logic                            syn_flag_i,
  input  logic                            ack_flag_i,
  input  logic                            fin_flag_i,
  input  logic                            rst_flag_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [3:0]                      conn_state_o,
  output logic [1:0]                      verdict_o,
  output logic [tct_pkg::TIMEOUT_W-1:0]    timeout_ticks_o,
  output logic                            is_active_o,
  output logic [1:0]                      active_change_o,
  output logic [tct_pkg::COUNT_W-1:0]      active_total_o,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tct_pkg::TIMEOUT_W-1:0]    established_timeout_i
);
  import tct_pkg::*;

  localparam int unsigned IDX_W = $clog2(CONN_ENTRIES);

  localparam logic [TIMEOUT_W-1:0] TICKS_2S  = TIMEOUT_W'(64'(TICKS_PER_SECOND) * 64'd2);
  localparam logic [TIMEOUT_W-1:0] TICKS_30S = TIMEOUT_W'(64'(TICKS_PER_SECOND) * 64'd30);
  localparam logic [TIMEOUT_W-1:0] TICKS_90S = TIMEOUT_W'(64'(TICKS_PER_SECOND) * 64'd90);

  // Timeout for a freshly applied state other than established
  function automatic logic [TIMEOUT_W-1:0] ticks_for(conn_state_e st);
    logic [TIMEOUT_W-1:0] t;
    case (st)
      ST_NONE:                        t = TICKS_2S;
      ST_SS, ST_SR, ST_FW, ST_CW, ST_LA: t = TICKS_30S;
      ST_ES:                          t = TICKS_90S;
      default:                        t = '0;
    endcase
    return t;
  endfunction

  // Pipeline control
  logic                    advance;
  logic                    accept;
  logic                    s1_valid_q;
  logic                    s2_valid_q;
  logic                    out_valid_q;
  logic                    retire;

  // Stage 1: accepted item
  logic                    s1_command_q;
  logic                    s1_dir_q;
  tct_class_e              s1_class_q;
  logic [CONN_INDEX_W-1:0] s1_index_q;
  logic [IDX_W-1:0]        rd_idx;

  // Stage 2: item with read data
  logic                    s2_command_q;
  logic                    s2_dir_q;
  tct_class_e              s2_class_q;
  logic [IDX_W-1:0]        s2_idx_q;
  tct_entry_t              rd_data_q;

  // Last write, for forwarding
  logic                    wr_valid_q;
  logic [IDX_W-1:0]        wr_idx_q;
  tct_entry_t              wr_data_q;

  // Update
  tct_entry_t              old_entry;
  tct_entry_t              new_entry;
  tct_next_e               nx;
  tct_verdict_e            verdict;
  tct_change_e             change;
  logic [COUNT_W-1:0]      count_d;
  logic [COUNT_W-1:0]      active_count_q;
  logic [TIMEOUT_W-1:0]    est_timeout_q;

  // Output register
  tct_entry_t              out_entry_q;
  tct_verdict_e            out_verdict_q;
  tct_change_e             out_change_q;

  tct_entry_t              entry_mem [CONN_ENTRIES];

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;
  assign retire     = s2_valid_q && advance;

  // Hold the configuration register; writes must come only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_timeout_q <= '0;
    end else if (cfg_valid_i) begin
      est_timeout_q <= established_timeout_i;
    end
  end

  // Advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_command_q <= command_i;
      s1_dir_q     <= reply_dir_i;
      s1_class_q   <= flag_class(syn_flag_i, ack_flag_i, fin_flag_i, rst_flag_i);
      s1_index_q   <= conn_index_i;
    end
  end

  // Reduce the index modulo the entry count
  if (CONN_ENTRIES < (1 << CONN_INDEX_W)) begin : g_reduce
    localparam int unsigned SHIFT   = CONN_INDEX_W + $clog2(CONN_ENTRIES);
    localparam int unsigned RECIP_W = CONN_INDEX_W + 2;
    localparam int unsigned PROD_W  = CONN_INDEX_W + RECIP_W;
    localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(CONN_ENTRIES) - 64'd1) / 64'(CONN_ENTRIES);

    logic [PROD_W-1:0]       prod;
    logic [CONN_INDEX_W-1:0] quot_q;
    logic [CONN_INDEX_W-1:0] rem;

    // Quotient by reciprocal multiply, exact for all 12-bit indexes
    assign prod = PROD_W'(conn_index_i) * PROD_W'(RECIP);

    always_ff @(posedge clk_i) begin
      if (accept) begin
        quot_q <= CONN_INDEX_W'(prod >> SHIFT);
      end
    end

    assign rem    = s1_index_q - CONN_INDEX_W'(quot_q * CONN_INDEX_W'(CONN_ENTRIES));
    assign rd_idx = IDX_W'(rem);
  end else begin : g_direct
    assign rd_idx = IDX_W'(s1_index_q);
  end

  // Read the entry as the item moves to stage 2
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      rd_data_q    <= entry_mem[rd_idx];
      s2_command_q <= s1_command_q;
      s2_dir_q     <= s1_dir_q;
      s2_class_q   <= s1_class_q;
      s2_idx_q     <= rd_idx;
    end
  end

  // Write back the updated entry
  always_ff @(posedge clk_i) begin
    if (retire) begin
      entry_mem[s2_idx_q] <= new_entry;
    end
  end

  // Track the last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else if (retire) begin
      wr_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      wr_idx_q  <= s2_idx_q;
      wr_data_q <= new_entry;
    end
  end

  // Forward the newest write to the same entry
  assign old_entry = (wr_valid_q && wr_idx_q == s2_idx_q) ? wr_data_q : rd_data_q;
  assign nx        = next_lookup(s2_dir_q, s2_class_q, old_entry.state);

  // Compute the new entry and verdict
  always_comb begin
    new_entry = old_entry;
    verdict   = VD_APPLIED;
    if (s2_command_q == CMD_OPEN) begin
      new_entry.state   = ST_NONE;
      new_entry.timeout = TICKS_2S;
      new_entry.active  = 1'b0;
    end else begin
      case (nx)
        NX_IG: verdict = VD_IGNORED;
        NX_IV: verdict = VD_INVALID;
        default: begin
          new_entry.state  = conn_state_e'(nx);
          new_entry.active = (nx == NX_ES);
          if (nx == NX_ES) begin
            new_entry.timeout = (est_timeout_q != '0) ? est_timeout_q : TICKS_90S;
          end else begin
            new_entry.timeout = ticks_for(conn_state_e'(nx));
          end
        end
      endcase
    end
  end

  // Update the active count, saturating both ways
  always_comb begin
    change  = CHG_NONE;
    count_d = active_count_q;
    if (new_entry.active && !old_entry.active) begin
      change = CHG_UP;
      if (active_count_q != '1) begin
        count_d = active_count_q + COUNT_W'(1);
      end
    end else if (!new_entry.active && old_entry.active) begin
      change = CHG_DOWN;
      if (active_count_q != '0) begin
        count_d = active_count_q - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
    end else if (retire) begin
      active_count_q <= count_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_entry_q   <= new_entry;
      out_verdict_q <= verdict;
      out_change_q  <= change;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign conn_state_o    = 4'(out_entry_q.state);
  assign verdict_o       = 2'(out_verdict_q);
  assign timeout_ticks_o = out_entry_q.timeout;
  assign is_active_o     = out_entry_q.active;
  assign active_change_o = 2'(out_change_q);
  assign active_total_o  = active_count_q;

`ifndef SYNTHESIS
  // The count moves only when an item retires
  a_count_moves_on_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !retire |=> $stable(active_count_q))
    else $error("active count changed without a retiring item");

  // A retiring item always lands in the output register
  a_retire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire |=> out_valid_q)
    else $error("retired item did not reach the output register");

  // Ignored or invalid packets never change the active mark
  a_no_change_when_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_verdict_q != VD_APPLIED) |-> (out_change_q == CHG_NONE))
    else $error("active mark changed on a kept entry");

  // A stalled output holds the pipeline still
  a_stall_holds_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(s1_valid_q) && $stable(s2_valid_q)))
    else $error("pipeline moved during an output stall");
`endif

endmodule

// ===== verif/tb_tcp_conntrack_state_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_conntrack_state_update
// Self-checking bench for the per-connection TCP tracking store.
// A directed table walks opens, every flag class and the error paths, then
// random connection lifecycles mixed with noise run under several timeout
// settings. Typed rows are checked against their own expected result, every other result against a behavioral tracker.
// ----------------------------------------------------------------------------
module tb_tcp_conntrack_state_update;
  import tct_pkg::*;

  localparam int unsigned ENTRIES = 4096;
  localparam int unsigned TPS     = 1000;

  localparam logic [TIMEOUT_W-1:0] NONE_TICKS = 2 * TPS;
  localparam logic [TIMEOUT_W-1:0] ES_TICKS   = 90 * TPS;

  typedef struct packed {
    logic                    command;
    logic [CONN_INDEX_W-1:0] idx;
    logic                    dir;
    logic                    syn;
    logic                    ack;
    logic                    fin;
    logic                    rst;
  } conn_item_t;

  typedef struct packed {
    conn_state_e          state;
    tct_verdict_e         verdict;
    logic [TIMEOUT_W-1:0] timeout;
    logic                 active;
    tct_change_e          change;
    logic [COUNT_W-1:0]   total;
  } conn_result_t;

  typedef struct packed {
    conn_item_t   item;
    logic         typed;
    conn_result_t want;
  } track_row_t;

  // Next state by direction, flag class and old state
  localparam tct_next_e TRANSITIONS [2][6][10] = '{
    '{
      '{NX_SS, NX_SS, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_SS, NX_SS, NX_S2},
      '{NX_IV, NX_IV, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_SR},
      '{NX_IV, NX_IV, NX_FW, NX_FW, NX_LA, NX_LA, NX_LA, NX_TW, NX_CL, NX_IV},
      '{NX_ES, NX_IV, NX_ES, NX_ES, NX_CW, NX_CW, NX_TW, NX_TW, NX_CL, NX_IV},
      '{NX_IV, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL},
      '{NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV}
    },
    '{
      '{NX_IV, NX_S2, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_S2},
      '{NX_IV, NX_SR, NX_SR, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_IG, NX_SR},
      '{NX_IV, NX_IV, NX_FW, NX_FW, NX_LA, NX_LA, NX_LA, NX_TW, NX_CL, NX_IV},
      '{NX_IV, NX_IG, NX_SR, NX_ES, NX_CW, NX_CW, NX_TW, NX_TW, NX_CL, NX_IG},
      '{NX_IV, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL, NX_CL},
      '{NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV, NX_IV}
    }
  };

  // Well-formed lifecycle after the open: handshake, data, close from both ends
  localparam int LIFE_STEPS = 9;
  localparam logic LIFE_DIR [LIFE_STEPS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                             1'b0, 1'b1, 1'b1, 1'b0};
  localparam tct_class_e LIFE_CLS [LIFE_STEPS] = '{CLS_SYN, CLS_SYNACK, CLS_ACK,
                                                   CLS_ACK, CLS_ACK, CLS_FIN,
                                                   CLS_ACK, CLS_FIN, CLS_ACK};

  // Directed table; rows with typed = 1 carry their own expected result
  localparam int DIRECTED_ROWS = 24;
  localparam track_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{CMD_OPEN,   12'h000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{ST_NONE, VD_APPLIED, NONE_TICKS, 1'b0, CHG_NONE, 13'd0}},
    '{'{CMD_OPEN,   12'hFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{ST_NONE, VD_APPLIED, NONE_TICKS, 1'b0, CHG_NONE, 13'd0}},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{ST_NONE, VD_INVALID, NONE_TICKS, 1'b0, CHG_NONE, 13'd0}},
    '{'{CMD_PACKET, 12'h000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_NONE, VD_INVALID, NONE_TICKS, 1'b0, CHG_NONE, 13'd0}},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_ES, VD_APPLIED, ES_TICKS, 1'b1, CHG_UP, 13'd1}},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'hFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{ST_NONE, VD_INVALID, NONE_TICKS, 1'b0, CHG_NONE, 13'd1}},
    '{'{CMD_PACKET, 12'hFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_OPEN,   12'hFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_OPEN,   12'hAAA, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{CMD_OPEN,   12'h555, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'hAAA, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'h555, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_PACKET, 12'hAAA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0}
  };

  logic                    clk_i     = 1'b0;
  logic                    rst_ni    = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    command   = CMD_PACKET;
  logic [CONN_INDEX_W-1:0] conn_idx  = '0;
  logic                    reply_dir = 1'b0;
  logic                    syn_flag  = 1'b0;
  logic                    ack_flag  = 1'b0;
  logic                    fin_flag  = 1'b0;
  logic                    rst_flag  = 1'b0;
  logic                    out_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [TIMEOUT_W-1:0]    cfg_data  = '0;

  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [3:0]              conn_state_o;
  logic [1:0]              verdict_o;
  logic [TIMEOUT_W-1:0]    timeout_ticks_o;
  logic                    is_active_o;
  logic [1:0]              active_change_o;
  logic [COUNT_W-1:0]      active_total_o;
  logic                    cfg_ready_o;

  // Tracker state
  conn_state_e          ent_state   [ENTRIES];
  logic [TIMEOUT_W-1:0] ent_timeout [ENTRIES];
  bit                   ent_active  [ENTRIES];
  bit                   opened      [ENTRIES];
  logic [COUNT_W-1:0]   active_sum = '0;
  logic [TIMEOUT_W-1:0] est_cfg    = '0;

  conn_result_t due_results [$];
  int           mismatches = 0;
  bit           steady     = 1'b0;

  tcp_conntrack_state_update #(
    .CONN_ENTRIES     (ENTRIES),
    .TICKS_PER_SECOND (TPS)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .command_i             (command),
    .conn_index_i          (conn_idx),
    .reply_dir_i           (reply_dir),
    .syn_flag_i            (syn_flag),
    .ack_flag_i            (ack_flag),
    .fin_flag_i            (fin_flag),
    .rst_flag_i            (rst_flag),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .conn_state_o          (conn_state_o),
    .verdict_o             (verdict_o),
    .timeout_ticks_o       (timeout_ticks_o),
    .is_active_o           (is_active_o),
    .active_change_o       (active_change_o),
    .active_total_o        (active_total_o),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready_o),
    .established_timeout_i (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle timeout held for a freshly applied state
  function automatic logic [TIMEOUT_W-1:0] state_ticks(conn_state_e st);
    case (st)
      ST_NONE:              return NONE_TICKS;
      ST_ES:                return (est_cfg != '0) ? est_cfg : ES_TICKS;
      ST_TW, ST_CL, ST_SS2: return '0;
      default:              return 30 * TPS;
    endcase
  endfunction

  // Advance the tracker by one item and return the result it must produce
  function automatic conn_result_t track_item(conn_item_t it);
    conn_result_t r;
    tct_class_e   cls;
    tct_next_e    nx;
    bit           was_act;
    bit           now_act;
    was_act   = ent_active[it.idx];
    now_act   = was_act;
    r.verdict = VD_APPLIED;
    if (it.command == CMD_OPEN) begin
      ent_state[it.idx]   = ST_NONE;
      ent_timeout[it.idx] = state_ticks(ST_NONE);
      now_act             = 1'b0;
    end else begin
      if (it.rst) cls = CLS_RST;
      else if (it.syn && it.ack) cls = CLS_SYNACK;
      else if (it.syn) cls = CLS_SYN;
      else if (it.fin) cls = CLS_FIN;
      else if (it.ack) cls = CLS_ACK;
      else cls = CLS_NONE;
      nx = TRANSITIONS[it.dir][cls][ent_state[it.idx]];
      if (nx == NX_IG) begin
        r.verdict = VD_IGNORED;
      end else if (nx == NX_IV) begin
        r.verdict = VD_INVALID;
      end else begin
        ent_state[it.idx]   = conn_state_e'(nx);
        ent_timeout[it.idx] = state_ticks(conn_state_e'(nx));
        now_act             = (nx == NX_ES);
      end
    end
    // Count entries entering or leaving established, saturating both ways
    r.change = CHG_NONE;
    if (now_act && !was_act) begin
      r.change = CHG_UP;
      if (active_sum != '1) active_sum++;
    end else if (!now_act && was_act) begin
      r.change = CHG_DOWN;
      if (active_sum != '0) active_sum--;
    end
    ent_active[it.idx] = now_act;
    r.state   = ent_state[it.idx];
    r.timeout = ent_timeout[it.idx];
    r.active  = now_act;
    r.total   = active_sum;
    return r;
  endfunction

  // Packet of a given flag class; flags the class leaves free are random
  function automatic conn_item_t shape_packet(logic [CONN_INDEX_W-1:0] idx, logic d,
                                              tct_class_e cls);
    conn_item_t it;
    it = '{CMD_PACKET, idx, d, 1'($urandom_range(1)), 1'($urandom_range(1)),
           1'($urandom_range(1)), 1'($urandom_range(1))};
    case (cls)
      CLS_RST:    it.rst = 1'b1;
      CLS_SYN:    {it.rst, it.syn, it.ack} = 3'b010;
      CLS_SYNACK: {it.rst, it.syn, it.ack} = 3'b011;
      CLS_FIN:    {it.rst, it.syn, it.fin} = 3'b001;
      CLS_ACK:    {it.rst, it.syn, it.fin, it.ack} = 4'b0001;
      default:    {it.rst, it.syn, it.fin, it.ack} = 4'b0000;
    endcase
    return it;
  endfunction

  // Open with random don't-care direction and flags
  function automatic conn_item_t open_item(logic [CONN_INDEX_W-1:0] idx);
    conn_item_t it;
    it = shape_packet(idx, 1'($urandom_range(1)), CLS_RST);
    it.command = CMD_OPEN;
    it.rst     = 1'($urandom_range(1));
    return it;
  endfunction

  // Present one item, hold it until the transfer, then queue its result
  task automatic drive_item(input conn_item_t it, input bit typed, input conn_result_t want);
    conn_result_t predicted;
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    command   <= it.command;
    conn_idx  <= it.idx;
    reply_dir <= it.dir;
    syn_flag  <= it.syn;
    ack_flag  <= it.ack;
    fin_flag  <= it.fin;
    rst_flag  <= it.rst;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = track_item(it);
    if (it.command == CMD_OPEN) opened[it.idx] = 1'b1;
    due_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every result is back and the pipeline drains
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_est_timeout(input logic [TIMEOUT_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    est_cfg = value;
  endtask

  // Result side: random stalls except during the steady window
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(99) >= 13);
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin
    conn_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (conn_state_o !== want.state) begin
          $error("conn_state: expected %0d, actual %0d", want.state, conn_state_o);
          mismatches++;
        end
        if (verdict_o !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, verdict_o);
          mismatches++;
        end
        if (timeout_ticks_o !== want.timeout) begin
          $error("timeout_ticks: expected %0d, actual %0d", want.timeout, timeout_ticks_o);
          mismatches++;
        end
        if (is_active_o !== want.active) begin
          $error("is_active: expected %0d, actual %0d", want.active, is_active_o);
          mismatches++;
        end
        if (active_change_o !== want.change) begin
          $error("active_change: expected %0d, actual %0d", want.change, active_change_o);
          mismatches++;
        end
        if (active_total_o !== want.total) begin
          $error("active_total: expected %0d, actual %0d", want.total, active_total_o);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed table, then random phases under different timeouts
  initial begin
    logic [CONN_INDEX_W-1:0] pool [16];
    int                      life_pos [16];
    logic [TIMEOUT_W-1:0]    phase_cfg;
    conn_item_t              it;
    int                      slot;
    int unsigned             roll;
    slot = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_est_timeout('0);
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      drive_item(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       phase_cfg = '1;
        1:       phase_cfg = 32'd1;
        2:       phase_cfg = $urandom();
        default: phase_cfg = '0;
      endcase
      write_est_timeout(phase_cfg);
      for (int k = 0; k < 16; k++) begin
        pool[k]     = CONN_INDEX_W'($urandom_range(ENTRIES - 1));
        life_pos[k] = 0;
      end
      for (int n = 0; n < 240; n++) begin
        steady = (ph == 1) && (n < 150);
        roll   = $urandom_range(99);
        // Mostly move between entries, sometimes hit the same one back to back
        if ($urandom_range(3) != 0) slot = $urandom_range(15);
        if (roll < 5) begin
          it = open_item(CONN_INDEX_W'($urandom_range(ENTRIES - 1)));
        end else if (roll < 30 && opened[pool[slot]]) begin
          it = shape_packet(pool[slot], 1'($urandom_range(1)),
                            tct_class_e'($urandom_range(5)));
        end else if (life_pos[slot] == 0 || !opened[pool[slot]]) begin
          it             = open_item(pool[slot]);
          life_pos[slot] = 1;
        end else begin
          it = shape_packet(pool[slot], LIFE_DIR[life_pos[slot] - 1],
                            LIFE_CLS[life_pos[slot] - 1]);
          // After time-wait either reopen or start a new handshake on it
          if (life_pos[slot] == LIFE_STEPS) begin
            life_pos[slot] = $urandom_range(1);
          end else begin
            life_pos[slot]++;
          end
        end
        drive_item(it, 1'b0, '0);
      end
      steady = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
